@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL, used by xxtea_block_cipher. Both rely on clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression must hold at every clock edge outside reset.
`define XX_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("xxtea: invariant violated");

// Antecedent in one cycle implies consequent in the next.
`define XX_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xxtea: sequence check failed");

`else

`define XX_ASSERT_ALWAYS(label, expr)
`define XX_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/xxtea_pkg.sv @@
`timescale 1ns / 1ps
package xxtea_pkg;

	localparam logic [31:0] XX_DELTA = 32'h9e3779b9;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned RND_W = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY0 = 3'd0,
		REG_KEY1 = 3'd1,
		REG_KEY2 = 3'd2,
		REG_KEY3 = 3'd3
	} xx_reg_t;

	typedef struct packed {
		logic        req_type;
		logic [31:0] data_word;
	} xx_in_t;

	typedef struct packed {
		logic [31:0] result_word;
		logic        last_word;
	} xx_out_t;

	// controller -> datapath commands
	typedef struct packed {
		logic       load;      // shift a new word in at the tail
		logic       start;     // initialise the round sum
		logic       step;      // one MX word update and rotate
		logic       round_end; // advance the round sum
		logic       shift_out; // result beat taken, rotate towards head
		logic       dec;       // decrypt mode
		logic [1:0] p_lo;      // low bits of the word index
	} xx_cmd_t;

endpackage

@@ rtl/xxtea_dp.sv @@
`timescale 1ns / 1ps
module xxtea_dp #(
	parameter int unsigned N_WORDS = 7,
	parameter int unsigned ROUNDS  = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  xxtea_pkg::xx_cmd_t               cmd,
	input  logic [31:0]                      data_word,
	input  logic                             cfg_we,
	input  logic [xxtea_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                      cfg_data,
	output logic [31:0]                      result_word
);
	import xxtea_pkg::*;

	localparam logic [63:0] SUM0_WIDE = 64'(ROUNDS) * 64'(XX_DELTA);
	localparam logic [31:0] DEC_SUM0  = SUM0_WIDE[31:0];

	logic [31:0] w_q [N_WORDS];
	logic [31:0] key_q [4];
	logic [31:0] sum_q;

	logic [31:0] z, y, k, mx, upd;
	logic [1:0]  kidx;

	// block kept as a rotating ring; z and y sit at fixed taps for each mode
	always_comb begin
		z    = cmd.dec ? w_q[N_WORDS-2] : w_q[N_WORDS-1];
		y    = cmd.dec ? w_q[0] : w_q[1];
		kidx = cmd.p_lo ^ sum_q[3:2];
		k    = key_q[kidx];
		mx   = (((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4))) ^ ((sum_q ^ y) + (k ^ z));
		upd  = cmd.dec ? (w_q[N_WORDS-1] - mx) : (w_q[0] + mx);
	end

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.shift_out || (cmd.step && !cmd.dec)) begin
			for (int i = 0; i < N_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[N_WORDS-1] <= cmd.load ? data_word : (cmd.step ? upd : w_q[0]);
		end else if (cmd.step) begin
			for (int i = 1; i < N_WORDS; i++) begin
				w_q[i] <= w_q[i-1];
			end
			w_q[0] <= upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
		end else begin
			if (cmd.start) begin
				sum_q <= cmd.dec ? DEC_SUM0 : XX_DELTA;
			end else if (cmd.round_end) begin
				sum_q <= cmd.dec ? (sum_q - XX_DELTA) : (sum_q + XX_DELTA);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY0: key_q[0] <= cfg_data;
					REG_KEY1: key_q[1] <= cfg_data;
					REG_KEY2: key_q[2] <= cfg_data;
					REG_KEY3: key_q[3] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign result_word = w_q[0];

endmodule

@@ rtl/xxtea_ctrl.sv @@
`timescale 1ns / 1ps
module xxtea_ctrl #(
	parameter int unsigned N_WORDS = 7,
	parameter int unsigned ROUNDS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  last_word,
	output xxtea_pkg::xx_cmd_t    cmd
);
	import xxtea_pkg::*;

	localparam int unsigned CW = $clog2(N_WORDS);
	localparam logic [CW-1:0] LAST_IDX = CW'(N_WORDS - 1);

	typedef enum logic [2:0] {
		S_LOAD = 3'b001,
		S_RUN  = 3'b010,
		S_OUT  = 3'b100
	} xx_state_t;

	xx_state_t        state_q;
	logic [CW-1:0]    cnt_q;
	logic [RND_W-1:0] rnd_q;
	logic             dec_q;
	logic             in_acc, out_acc;
	logic [CW-1:0]    p_idx;

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OUT);
	assign last_word = (cnt_q == LAST_IDX);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign p_idx     = dec_q ? (LAST_IDX - cnt_q) : cnt_q;

	always_comb begin
		cmd           = '0;
		cmd.dec       = dec_q;
		cmd.p_lo      = 2'(p_idx);
		cmd.load      = in_acc;
		cmd.start     = in_acc && (cnt_q == LAST_IDX);
		cmd.step      = (state_q == S_RUN);
		cmd.round_end = (state_q == S_RUN) && (cnt_q == LAST_IDX);
		cmd.shift_out = out_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			rnd_q   <= '0;
			dec_q   <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (cnt_q == '0) begin
							dec_q <= req_type;
						end
						if (cnt_q == LAST_IDX) begin
							cnt_q   <= '0;
							rnd_q   <= RND_W'(ROUNDS);
							state_q <= S_RUN;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				S_RUN: begin
					if (cnt_q == LAST_IDX) begin
						cnt_q <= '0;
						rnd_q <= rnd_q - RND_W'(1);
						if (rnd_q == RND_W'(1)) begin
							state_q <= S_OUT;
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_OUT: begin
					if (out_acc) begin
						if (cnt_q == LAST_IDX) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
					cnt_q   <= '0;
				end
			endcase
		end
	end

endmodule

@@ rtl/xxtea_block_cipher.sv @@
`timescale 1ns / 1ps
// XXTEA block cipher over a block of N_WORDS 32-bit words. Words arrive one
// beat each, word 0 first; req_type on the first beat picks encrypt (0) or
// decrypt (1). Once the last word is in, EXTRA_ROUNDS + 52/N_WORDS rounds run
// on a single MX unit that updates one word per cycle. The N_WORDS results
// then leave in index order, last_word set on the final beat. Input is not
// taken while a block runs or drains. Key words are written at indices 0..3
// and are read as they stand while the block runs, not captured when the
// last word arrives; other indices are ignored. Keys reset to zero.
`include "assert_macros.svh"
module xxtea_block_cipher #(
	parameter int unsigned N_WORDS      = 7,
	parameter int unsigned EXTRA_ROUNDS = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  xxtea_pkg::xx_in_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output xxtea_pkg::xx_out_t               out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [xxtea_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                      cfg_data
);
	import xxtea_pkg::*;

	// full rounds per block
	localparam int unsigned ROUNDS = EXTRA_ROUNDS + 52 / N_WORDS;

	xx_cmd_t     cmd;
	logic        last_word;
	logic [31:0] result_word;

	// key registers are always writable; writes must only come while idle, which the block itself does not enforce
	assign cfg_ready = 1'b1;

	xxtea_ctrl #(
		.N_WORDS (N_WORDS),
		.ROUNDS  (ROUNDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (in_data.req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.last_word (last_word),
		.cmd       (cmd)
	);

	// datapath: word ring, key registers, round sum and the MX unit
	xxtea_dp #(
		.N_WORDS (N_WORDS),
		.ROUNDS  (ROUNDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_word   (in_data.data_word),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_word (result_word)
	);

	assign out_data.result_word = result_word;
	assign out_data.last_word   = last_word;

	// loading and draining never overlap
	`XX_ASSERT_ALWAYS(a_no_load_while_draining, !(in_ready && out_valid))
	// the run phase never issues beat-level commands
	`XX_ASSERT_ALWAYS(a_step_excl, !(cmd.step && (cmd.load || cmd.shift_out)))
	// after the last result beat the block returns to loading
	`XX_ASSERT_NEXT(a_last_ends_block, out_valid && out_ready && out_data.last_word, in_ready && !out_valid)
	// results only follow a finished run, never straight out of loading
	`XX_ASSERT_NEXT(a_run_before_out, in_ready, !out_valid)

endmodule
